/* rtl/isia_pkg.sv */
// Shared types and constants for the integer set id assigner.
// Holds operation codes, controller states and the command/status structs.
// No dependencies.
package isia_pkg;

  // Field widths of the stream words
  localparam int unsigned ItemW     = 32;
  localparam int unsigned OpW       = 2;
  localparam int unsigned IdxOutW   = 9;
  localparam int unsigned CntOutW   = 9;
  localparam int unsigned OutDataW  = 24;
  localparam int unsigned DepthDef  = 256;

  // Operation codes carried in s_axis_tuser
  typedef enum logic [OpW-1:0] {
    OP_ADD   = 2'd0,
    OP_HAS   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SORT  = 2'd3
  } op_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SORT_NEXT,
    ST_SORT_KEY,
    ST_SORT_STEP,
    ST_SORT_CMP,
    ST_FINISH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming word, reset the pointer
    logic scan_rd;   // read entry at pointer, advance pointer
    logic key_rd;    // read sort key at pointer
    logic key_ld;    // load key from read data, j = pointer
    logic prev_rd;   // read entry at j-1
    logic shift;     // store[j] = read data, j--
    logic put;       // store[j] = key, advance pointer
    logic append;    // store item at count, count++
    logic clear;     // empty the set
    logic emit;      // load the result word
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_e  op;         // latched operation
    logic hit_now;    // compare in flight matches the item
    logic rvalid;     // a scan read is being compared
    logic ptr_below;  // pointer below entry count
    logic full;       // entry count reached depth
    logic hit;        // a match was recorded
    logic j_zero;     // insertion point at entry zero
    logic less;       // key below the entry just read
    logic out_free;   // result register can take a word
  } sts_t;

endpackage

/* rtl/isia_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module isia_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/isia_dp.sv */
// Datapath of the integer set id assigner: item store, pointers, compare
// logic and the result register. Depends on isia_pkg and isia_ram.
module isia_dp
  import isia_pkg::*;
#(
  parameter int unsigned Depth = DepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [OpW-1:0]      op_i,
  input  logic [ItemW-1:0]    item_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [OutDataW-1:0] m_data_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  op_e              op_q;
  logic [ItemW-1:0] item_q;
  logic [ItemW-1:0] key_q;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    ptr_q;
  logic [CW-1:0]    j_q;
  logic [CW-1:0]    jm1;
  logic [AW-1:0]    rd_idx_q;
  logic             rvalid_q;
  logic             hit_q;
  logic [AW-1:0]    hit_idx_q;
  logic             full;
  logic             hit_now;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [ItemW-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [ItemW-1:0] rdata;

  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  logic               found_d;
  logic               err_d;
  logic [IdxOutW-1:0] index_d;
  logic [31:0]        idx_wide;
  logic [31:0]        cnt_wide_old;
  logic [31:0]        cnt_wide;

  assign full    = (count_q == CW'(Depth));
  assign hit_now = rvalid_q && (rdata == item_q);
  assign jm1     = j_q - CW'(1);

  // Store writes: append, shift during sort, key placement
  assign we    = cmd_i.append | cmd_i.shift | cmd_i.put;
  assign waddr = cmd_i.append ? count_q[AW-1:0] : j_q[AW-1:0];
  assign wdata = cmd_i.append ? item_q : (cmd_i.shift ? rdata : key_q);
  assign raddr = cmd_i.prev_rd ? jm1[AW-1:0] : ptr_q[AW-1:0];

  isia_ram #(
    .Width (ItemW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Entry count
  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.append) begin
      count_d = count_q + CW'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rvalid_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      count_q  <= count_d;
      rvalid_q <= cmd_i.scan_rd;
      if (cmd_i.capture) begin
        hit_q <= 1'b0;
      end else if (hit_now) begin
        hit_q <= 1'b1;
      end
    end
  end

  // Payload and pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(op_i);
      item_q <= item_i;
      ptr_q  <= (op_e'(op_i) == OP_SORT) ? CW'(1) : '0;
    end else if (cmd_i.scan_rd || cmd_i.put) begin
      ptr_q <= ptr_q + CW'(1);
    end
    if (cmd_i.scan_rd) begin
      rd_idx_q <= ptr_q[AW-1:0];
    end
    if (hit_now) begin
      hit_idx_q <= rd_idx_q;
    end
    if (cmd_i.key_ld) begin
      key_q <= rdata;
      j_q   <= ptr_q;
    end else if (cmd_i.shift) begin
      j_q <= jm1;
    end
  end

  // Result fields
  always_comb begin
    idx_wide     = 32'(hit_idx_q);
    cnt_wide_old = 32'(count_q);
    cnt_wide     = 32'(count_d);
    found_d      = 1'b0;
    err_d        = 1'b0;
    index_d      = '1;
    case (op_q)
      OP_ADD: begin
        if (hit_q) begin
          found_d = 1'b1;
          index_d = idx_wide[IdxOutW-1:0];
        end else if (full) begin
          err_d = 1'b1;
        end else begin
          index_d = cnt_wide_old[IdxOutW-1:0];
        end
      end
      OP_HAS: begin
        if (hit_q) begin
          found_d = 1'b1;
          index_d = idx_wide[IdxOutW-1:0];
        end
      end
      default: begin
      end
    endcase
    m_data_d = {{(OutDataW - 20){1'b0}}, cnt_wide[CntOutW-1:0], err_d, index_d, found_d};
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  // Status to the controller
  always_comb begin
    sts_o           = '0;
    sts_o.op        = op_q;
    sts_o.hit_now   = hit_now;
    sts_o.rvalid    = rvalid_q;
    sts_o.ptr_below = (ptr_q < count_q);
    sts_o.full      = full;
    sts_o.hit       = hit_q;
    sts_o.j_zero    = (j_q == '0);
    sts_o.less      = ($signed(key_q) < $signed(rdata));
    sts_o.out_free  = !m_valid_q || m_ready_i;
  end

`ifndef SYNTH
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("entry count above depth");

  a_append_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> !full)
    else $error("append into a full store");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!m_valid_q || m_ready_i))
    else $error("result word overwritten before taken");

  a_shift_moves_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> (j_q != '0))
    else $error("sort shift below entry zero");
`endif

endmodule

/* rtl/isia_ctrl.sv */
// Controller state machine of the integer set id assigner: sequences the
// lookup scan, the insertion sort and the result. Depends on isia_pkg.
module isia_ctrl
  import isia_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  logic [OpW-1:0] op_i,
  input  sts_t           sts_i,
  output cmd_t           cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          case (op_e'(op_i))
            OP_ADD, OP_HAS: state_d = ST_LOOKUP;
            OP_SORT:        state_d = ST_SORT_NEXT;
            default:        state_d = ST_FINISH;
          endcase
        end
      end
      ST_LOOKUP: begin
        // stop on a match, drain the last compare before giving up
        if (sts_i.hit_now) begin
          state_d = ST_FINISH;
        end else if (sts_i.ptr_below) begin
          cmd_o.scan_rd = 1'b1;
        end else if (!sts_i.rvalid) begin
          state_d = ST_FINISH;
        end
      end
      ST_SORT_NEXT: begin
        if (sts_i.ptr_below) begin
          cmd_o.key_rd = 1'b1;
          state_d      = ST_SORT_KEY;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SORT_KEY: begin
        cmd_o.key_ld = 1'b1;
        state_d      = ST_SORT_STEP;
      end
      ST_SORT_STEP: begin
        if (sts_i.j_zero) begin
          cmd_o.put = 1'b1;
          state_d   = ST_SORT_NEXT;
        end else begin
          cmd_o.prev_rd = 1'b1;
          state_d       = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        if (sts_i.less) begin
          cmd_o.shift = 1'b1;
          state_d     = ST_SORT_STEP;
        end else begin
          cmd_o.put = 1'b1;
          state_d   = ST_SORT_NEXT;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.append = (sts_i.op == OP_ADD) && !sts_i.hit && !sts_i.full;
          cmd_o.clear  = (sts_i.op == OP_CLEAR);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q != ST_IDLE))
    else $error("accepted word did not start work");

  a_emit_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (state_q == ST_IDLE))
    else $error("result emitted without returning to idle");

  a_one_store_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.append, cmd_o.shift, cmd_o.put}) <= 1)
    else $error("conflicting store writes");
`endif

endmodule

/* rtl/integer_set_id_assigner_core.sv */
// Integer set id assigner: one word in, one result word out.
// Add/has: linear store scan from accept to result, one RAM read per
// cycle. Sort: insertion sort over the store, which has one write and one
// read port, moving each greater entry up one place until the key fits.
// One word is worked on at a time.
// Reset (rst_ni, async, active low) empties the set; no clearing pass.
module integer_set_id_assigner_core
  import isia_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ItemW-1:0]    s_axis_tdata,   // [31:0] item
  input  logic [OpW-1:0]      s_axis_tuser,   // [1:0] operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [0] found, [9:1] index,
                                              // [10] error_full, [19:11] count
);

  cmd_t cmd;
  sts_t sts;

  isia_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .op_i      (s_axis_tuser),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  isia_dp #(
    .Depth (DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .op_i      (s_axis_tuser),
    .item_i    (s_axis_tdata),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule
